>>> rtl/assert_macros.svh
// Assertion macros included by the RTL top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/rrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrc_pkg;
    localparam int CW = 36;
    localparam int ZW = 34;
    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam int ATAN_N = 24;
    localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };
    localparam logic signed [63:0] POS_MAX = 64'sd1048575;
    localparam logic signed [63:0] POS_MIN = -64'sd1048576;

    typedef struct packed {
        logic signed [CW-1:0] hx;
        logic signed [CW-1:0] hy;
        logic signed [ZW-1:0] hz;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [ZW-1:0] vz;
    } rrc_rot_t;
endpackage
`default_nettype wire

>>> rtl/rrc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rrc_cell
    import rrc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic     clk,
    input  wire logic     en,
    input  wire rrc_rot_t din,
    output rrc_rot_t      dout
);
    rrc_rot_t dout_reg;
    rrc_rot_t dout_next;
    logic signed [ZW-1:0] at;

    assign at = ZW'($signed({1'b0, ATAN_TURN32[STAGE]}));

    always_comb
    begin
        dout_next = din;
        if (!din.hz[ZW-1])
        begin
            dout_next.hx = din.hx - (din.hy >>> STAGE);
            dout_next.hy = din.hy + (din.hx >>> STAGE);
            dout_next.hz = din.hz - at;
        end
        else
        begin
            dout_next.hx = din.hx + (din.hy >>> STAGE);
            dout_next.hy = din.hy - (din.hx >>> STAGE);
            dout_next.hz = din.hz + at;
        end
        if (!din.vz[ZW-1])
        begin
            dout_next.vx = din.vx - (din.vy >>> STAGE);
            dout_next.vy = din.vy + (din.vx >>> STAGE);
            dout_next.vz = din.vz - at;
        end
        else
        begin
            dout_next.vx = din.vx + (din.vy >>> STAGE);
            dout_next.vy = din.vy - (din.vx >>> STAGE);
            dout_next.vz = din.vz + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

>>> rtl/radar_reflection_to_cartesian_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake           | Payload
// input   | in_valid/in_stall   | flight_time_ps, azimuth_angle, elevation_angle,
//         |                     | strength_db, cloud_end
// output  | out_valid/out_stall | pos_x_mm, pos_y_mm, pos_z_mm, intensity_db,
//         |                     | cloud_last
// One item per cycle while the output is not stalled; an item passes through the
// CORDIC cell row, two product stages and the output register.
// The range is worked out in three stages beside the first cells.
// The whole pipeline advances together and freezes while the output is
// stalled with a valid item in the output register. Reset clears only the
// valid bits.
`include "assert_macros.svh"
module radar_reflection_to_cartesian_top
    import rrc_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FLIGHT_TIME_BITS = 22,
    parameter int TRIG_STAGES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [21:0]        flight_time_ps,
    input  wire logic signed [15:0] azimuth_angle,
    input  wire logic signed [15:0] elevation_angle,
    input  wire logic signed [15:0] strength_db,
    input  wire logic               cloud_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [20:0]      pos_x_mm,
    output logic signed [20:0]      pos_y_mm,
    output logic signed [20:0]      pos_z_mm,
    output logic signed [15:0]      intensity_db,
    output logic                    cloud_last
);
    localparam int NS = (TRIG_STAGES < ATAN_N) ? TRIG_STAGES : ATAN_N;
    localparam int DEPTH = NS + 3;
    localparam int FTW = (FLIGHT_TIME_BITS < 22) ? FLIGHT_TIME_BITS : 22;
    localparam int AW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int RW = 24;
    localparam logic [RW-1:0] DIV_LO = 24'd1953125;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic             flip_h;
    logic             flip_v;
    logic [31:0]      uh;
    logic [31:0]      uv;
    rrc_rot_t         rot_in;
    rrc_rot_t         chain [NS+1];

    assign adv = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // Fold the angle into the right half plane before the rotation row.
    always_comb
    begin
        uh = 32'(azimuth_angle[AW-1:0]) << (32 - ANGLE_BITS);
        uv = 32'(elevation_angle[AW-1:0]) << (32 - ANGLE_BITS);
        flip_h = uh[31] ^ uh[30];
        flip_v = uv[31] ^ uv[30];
        if (flip_h)
        begin
            uh = uh + 32'h80000000;
        end
        if (flip_v)
        begin
            uv = uv + 32'h80000000;
        end
        rot_in.hx = GAIN_Q30;
        rot_in.hy = '0;
        rot_in.hz = ZW'($signed(uh));
        rot_in.vx = GAIN_Q30;
        rot_in.vy = '0;
        rot_in.vz = ZW'($signed(uv));
    end

    assign chain[0] = rot_in;

    // Side data travels beside the cells.
    logic [RW-1:0] rng_sh   [2:NS-1];
    logic          fh_sh    [NS];
    logic          fv_sh    [NS];
    logic [15:0]   str_sh   [NS+2];
    logic          last_sh  [NS+2];

    // Range: (t * c / 2 + 5e8) / 1e9. The low 9 bits of 1e9 go by a shift,
    // the rest is a reciprocal estimate that is at most one low and gets
    // fixed by one compare on the remainder.
    logic [49:0]   rp;
    logic [40:0]   rq_reg;
    logic [52:0]   qm;
    logic [RW-1:0] q0_reg;
    logic [22:0]   qlo_reg;
    logic [22:0]   rem;
    logic [RW-1:0] q_fix;

    assign rp = 50'(flight_time_ps[FTW-1:0]) * 50'd149896229 + 50'd500000000;
    assign qm = 53'(rq_reg[40:20]) * 53'd2305843009;
    assign rem = qlo_reg - 23'(q0_reg * DIV_LO);
    assign q_fix = q0_reg + RW'(rem >= 23'(DIV_LO));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rq_reg <= rp[49:9];
            q0_reg <= RW'(qm[52:32]);
            qlo_reg <= rq_reg[22:0];
            rng_sh[2] <= q_fix;
            fh_sh[0] <= flip_h;
            fv_sh[0] <= flip_v;
            str_sh[0] <= strength_db;
            last_sh[0] <= cloud_end;
            for (int i = 3; i < NS; i++)
            begin
                rng_sh[i] <= rng_sh[i-1];
            end
            for (int i = 1; i < NS; i++)
            begin
                fh_sh[i] <= fh_sh[i-1];
                fv_sh[i] <= fv_sh[i-1];
            end
            for (int i = 1; i < NS + 2; i++)
            begin
                str_sh[i] <= str_sh[i-1];
                last_sh[i] <= last_sh[i-1];
            end
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        rrc_cell #(.STAGE(g)) u_cell (
            .clk (clk),
            .en  (adv),
            .din (chain[g]),
            .dout(chain[g+1])
        );
    end

    // Sine and cosine stay within one in Q30, so 32 bits hold them.
    logic signed [31:0] hc;
    logic signed [31:0] hs;
    logic signed [31:0] vc;
    logic signed [31:0] vs;
    assign hc = 32'(fh_sh[NS-1] ? -chain[NS].hx : chain[NS].hx);
    assign hs = 32'(fh_sh[NS-1] ? -chain[NS].hy : chain[NS].hy);
    assign vc = 32'(fv_sh[NS-1] ? -chain[NS].vx : chain[NS].vx);
    assign vs = 32'(fv_sh[NS-1] ? -chain[NS].vy : chain[NS].vy);

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [63:0] px_mul, py_mul;
    logic [RW-1:0]      rng_p_reg;
    assign px_mul = 64'(hc) * 64'(vc) + 64'sd536870912;
    assign py_mul = 64'(hs) * 64'(vc) + 64'sd536870912;

    logic signed [63:0] cx_reg, cy_reg, cz_reg;
    logic signed [63:0] cx, cy, cz;
    assign cx = 64'($signed({1'b0, rng_p_reg})) * 64'(px_reg) + 64'sd536870912;
    assign cy = 64'($signed({1'b0, rng_p_reg})) * 64'(py_reg) + 64'sd536870912;
    assign cz = 64'($signed({1'b0, rng_p_reg})) * 64'(pz_reg) + 64'sd536870912;

    function automatic logic signed [20:0] sat(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v >>> 30;
        if (s > POS_MAX)
        begin
            return 21'sd1048575;
        end
        if (s < POS_MIN)
        begin
            return -21'sd1048576;
        end
        return 21'(s);
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= 32'(px_mul >>> 30);
            py_reg <= 32'(py_mul >>> 30);
            pz_reg <= vs;
            rng_p_reg <= rng_sh[NS-1];
            cx_reg <= cx;
            cy_reg <= cy;
            cz_reg <= cz;
            pos_x_mm <= sat(cx_reg);
            pos_y_mm <= sat(cy_reg);
            pos_z_mm <= sat(cz_reg);
            intensity_db <= str_sh[NS+1];
            cloud_last <= last_sh[NS+1];
        end
    end

    `ASSERT_IMPLIES(a_stall_hold, clk, rst_n, out_valid && out_stall, in_stall)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_IMPLIES(a_no_stall_empty, clk, rst_n, !out_valid, !in_stall)
endmodule
`default_nettype wire
